@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Each macro expands to one labeled concurrent assertion on clk; STG_ASSERT uses rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define STG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define STG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/stg_pkg.sv @@
// Shared types, constants and the quarter-wave sine table of the tone generator.
// No dependencies; imported by stg_front, stg_queue, stg_back and the core module.
`default_nettype none

package stg_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int AMPLITUDE_BITS  = 16;

  localparam int QSIZE = 1 << TABLE_ADDR_BITS;
  localparam int MAG_W = AMPLITUDE_BITS - 1;
  localparam int IDX_W = TABLE_ADDR_BITS + 1;

  localparam logic [31:0] FMT_MONO16   = 32'h0010_0001;
  localparam logic [31:0] FMT_STEREO16 = 32'h0010_0002;
  localparam logic [31:0] OUT_MAX      = 32'd32767;
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam logic [63:0] AMP          = (64'd1 << (AMPLITUDE_BITS - 1)) - 64'd1;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_PHASE_STEP    = 2'd0;
  localparam logic [1:0] REG_TONE_LENGTH   = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
  localparam logic [1:0] REG_SAMPLE_BITS   = 2'd3;

  localparam logic [31:0] PHASE_STEP_RST    = 32'd0;
  localparam logic [23:0] TONE_LENGTH_RST   = 24'd0;
  localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd1;
  localparam logic [5:0]  SAMPLE_BITS_RST   = 6'd16;

  // Queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [31:0] phase_step;
    logic [23:0] tone_length;
    logic [3:0]  channel_count;
    logic [5:0]  sample_bits;
  } cfg_t;

  // One classified tick, as handed from front to back.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             neg;
    logic             valid_res;
    logic             last;
    logic             format_error;
    logic             stereo;
  } desc_t;

  typedef logic [MAG_W-1:0] quarter_t [0:QSIZE];

  // Taylor divisors (2n)(2n+1) for n = 1..8.
  localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

  // Q30 sine through x^17, truncating shifts; elaboration only.
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (int n = 1; n <= 8; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n];
      if (n % 2 == 1) neg = neg + term;
      else            pos = pos + term;
    end
    return (pos > neg) ? pos - neg : 64'd0;
  endfunction

  function automatic quarter_t build_quarter();
    quarter_t    q;
    logic [63:0] x;
    logic [63:0] v;
    for (int k = 0; k <= QSIZE; k++) begin
      x = (64'(k) * HALF_PI_Q30) / QSIZE;
      v = (sine_q30(x) * AMP + (64'd1 << 29)) >> 30;
      if (v > AMP) v = AMP;
      q[k] = MAG_W'(v);
    end
    return q;
  endfunction

  localparam quarter_t QUARTER = build_quarter();

endpackage

`default_nettype wire

@@ hw/rtl/stg_front.sv @@
// Front end: takes sample ticks, updates phase and sample count, classifies the tick.
// Depends on stg_pkg; feeds stg_queue.
`default_nettype none

module stg_front import stg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  start_req,
  input  wire logic  q_full,
  output logic       push,
  output desc_t      desc
);

  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic [23:0]           cnt_r, cnt_nxt;

  logic [PHASE_BITS-1:0]      ph;
  logic [23:0]                cnt;
  logic [31:0]                fmt;
  logic                       fmt_ok;
  logic                       run;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] k;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    ph     = start_req ? '0 : phase_r;
    cnt    = start_req ? '0 : cnt_r;
    fmt    = {10'd0, cfg.sample_bits, 12'd0, cfg.channel_count};
    fmt_ok = (fmt == FMT_MONO16) || (fmt == FMT_STEREO16);
    run    = fmt_ok && (cnt < cfg.tone_length);
    quad   = ph[PHASE_BITS-1 -: 2];
    k      = ph[PHASE_BITS-3 -: TABLE_ADDR_BITS];

    desc.idx          = quad[0] ? (IDX_W'(QSIZE) - {1'b0, k}) : {1'b0, k};
    desc.neg          = quad[1];
    desc.valid_res    = run;
    desc.last         = run && ((cnt + 24'd1) == cfg.tone_length);
    desc.format_error = !fmt_ok;
    desc.stereo       = (fmt == FMT_STEREO16);

    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    if (push) begin
      phase_nxt = run ? ph + PHASE_BITS'(cfg.phase_step) : ph;
      cnt_nxt   = run ? cnt + 24'd1 : cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stg_queue.sv @@
// Short FIFO of classified ticks between front and back.
// Depends on stg_pkg (desc_t, QDEPTH).
`default_nettype none

module stg_queue import stg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t wr_data,
  input  wire logic  pop,
  output desc_t      rd_data,
  output logic       full,
  output logic       empty
);

  desc_t             mem_r [0:QDEPTH-1];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full    = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stg_back.sv @@
// Back end: table read, sign and channel mapping, output register.
// Depends on stg_pkg (QUARTER table, desc_t); drains stg_queue.
`default_nettype none

module stg_back import stg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  input  wire desc_t q_data,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [15:0] left,
  output logic [15:0] right,
  output logic       valid_res,
  output logic       last,
  output logic       format_error
);

  logic             s1_valid_r, s1_valid_nxt;
  desc_t            s1_desc_r;
  logic [MAG_W-1:0] rom_r;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] left_r, right_r;
  logic        valid_res_r, last_r, format_error_r;

  logic        s1_adv;
  logic [14:0] mag;
  logic [15:0] smp;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_ready);
  assign pop    = !q_empty && (!s1_valid_r || s1_adv);

  always_comb begin
    s1_valid_nxt  = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

    if (32'(rom_r) > OUT_MAX) mag = OUT_MAX[14:0];
    else                      mag = 15'(rom_r);
    smp = s1_desc_r.neg ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
    if (!s1_desc_r.valid_res) smp = '0;
  end

  // Table read registered with the descriptor it belongs to.
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_desc_r <= q_data;
      rom_r     <= QUARTER[q_data.idx];
    end
    if (s1_adv) begin
      left_r         <= smp;
      right_r        <= s1_desc_r.stereo ? smp : 16'd0;
      valid_res_r    <= s1_desc_r.valid_res;
      last_r         <= s1_desc_r.last;
      format_error_r <= s1_desc_r.format_error;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign left         = left_r;
  assign right        = right_r;
  assign valid_res    = valid_res_r;
  assign last         = last_r;
  assign format_error = format_error_r;

endmodule

`default_nettype wire

@@ hw/rtl/sine_tone_generator_core.sv @@
// A tick passes the queue, table-read register and output register to out_*.
// One tick per cycle unless stalled; the phase add and a table read limit it.
// in_tready drops only when the four-entry queue is full (output stalled).
// Reset (rst_n low, synchronous): phase and sample count cleared, registers to
// reset values, queue and pipeline emptied; no clearing pass.
`default_nettype none

module sine_tone_generator_core import stg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [0] start_req, [7:1] zero
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  // out_tdata: [15:0] sample_left, [31:16] sample_right
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  // out_tuser: [0] valid_res, [1] format_error
  output logic [1:0]       out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t  cfg_r, cfg_nxt;
  logic  wr_en;

  logic  push, pop, q_full, q_empty;
  desc_t f_desc, q_desc;

  logic [15:0] left, right;
  logic        valid_res, format_error;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_PHASE_STEP:    cfg_nxt.phase_step    = cfg_pwdata;
        REG_TONE_LENGTH:   cfg_nxt.tone_length   = cfg_pwdata[23:0];
        REG_CHANNEL_COUNT: cfg_nxt.channel_count = cfg_pwdata[3:0];
        REG_SAMPLE_BITS:   cfg_nxt.sample_bits   = cfg_pwdata[5:0];
        default: ;
      endcase
    end

    case (cfg_paddr[3:2])
      REG_PHASE_STEP:    cfg_prdata = cfg_r.phase_step;
      REG_TONE_LENGTH:   cfg_prdata = {8'd0, cfg_r.tone_length};
      REG_CHANNEL_COUNT: cfg_prdata = {28'd0, cfg_r.channel_count};
      REG_SAMPLE_BITS:   cfg_prdata = {26'd0, cfg_r.sample_bits};
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_step    <= PHASE_STEP_RST;
      cfg_r.tone_length   <= TONE_LENGTH_RST;
      cfg_r.channel_count <= CHANNEL_COUNT_RST;
      cfg_r.sample_bits   <= SAMPLE_BITS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  stg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .start_req (in_tdata[0]),
    .q_full    (q_full),
    .push      (push),
    .desc      (f_desc)
  );

  stg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (f_desc),
    .pop     (pop),
    .rd_data (q_desc),
    .full    (q_full),
    .empty   (q_empty)
  );

  stg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_desc),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .left         (left),
    .right        (right),
    .valid_res    (valid_res),
    .last         (out_tlast),
    .format_error (format_error)
  );

  assign out_tdata = {right, left};
  assign out_tuser = {format_error, valid_res};

endmodule

`default_nettype wire

@@ hw/rtl/stg_checker.sv @@
// Port-level checks on the tone generator's result stream, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module stg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic [1:0]  out_tuser
);

  `STG_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `STG_ASSERT(a_last_valid, out_tvalid && out_tlast |-> out_tuser[0], "last on an invalid sample")
  `STG_ASSERT(a_err_silent, out_tvalid && out_tuser[1] |-> !out_tuser[0] && out_tdata == 32'd0, "format error with audio")
  `STG_ASSERT(a_idle_zero, out_tvalid && !out_tuser[0] |-> out_tdata == 32'd0 && !out_tlast, "nonzero invalid sample")

endmodule

bind sine_tone_generator_core stg_checker u_stg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
